// File: hdl/acs_pkg.sv
`default_nettype none
package acs_pkg;

  // fixed widths of the beat fields
  localparam int FIELD_W = 8;
  localparam int MASK_W  = 16;
  localparam int TOTAL_W = 5;

  // widest coordinate the cell builder supports
  localparam int COORD_MAX = 16;

  // defaults for the top level parameters
  localparam int MAX_AGENTS_DEF = 16;
  localparam int COORD_BITS_DEF = 8;

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ_I,
    S_LATCH,
    S_SWEEP,
    S_OUT
  } state_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic latch;       // capture the agent under test from the read data
    logic cmp;         // read data holds a valid sweep entry
    logic self_agent;  // that entry is the agent under test
  } cmp_ctl_t;

endpackage
`default_nettype wire

// File: hdl/acs_in_if.sv
`default_nettype none
interface acs_in_if import acs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] new_row;
  logic [FIELD_W-1:0] new_col;
  logic [FIELD_W-1:0] old_row;
  logic [FIELD_W-1:0] old_col;
  logic               last_agent;

  modport source (
    output valid, new_row, new_col, old_row, old_col, last_agent,
    input  ready
  );

  modport sink (
    input  valid, new_row, new_col, old_row, old_col, last_agent,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/acs_out_if.sv
`default_nettype none
interface acs_out_if import acs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  collision_mask;
  logic [TOTAL_W-1:0] agent_total;
  logic               overflow;

  modport source (
    output valid, collision_mask, agent_total, overflow,
    input  ready
  );

  modport sink (
    input  valid, collision_mask, agent_total, overflow,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/acs_ram.sv
`default_nettype none
module acs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/acs_cmp.sv
`default_nettype none
module acs_cmp import acs_pkg::*; #(
  parameter int CELL_W = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmp_ctl_t          ctl,
  input  wire logic [CELL_W-1:0] new_rd,
  input  wire logic [CELL_W-1:0] old_rd,
  output logic                   collide
);

  logic [CELL_W-1:0] cur_new;
  logic [CELL_W-1:0] cur_old;
  logic              vertex_hit;
  logic              swap_found;
  logic              swap_hit;

  // cells of the agent under test carry no reset
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cur_new <= new_rd;
      cur_old <= old_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_hit <= 1'b0;
      swap_found <= 1'b0;
      swap_hit   <= 1'b0;
    end else if (ctl.latch) begin
      vertex_hit <= 1'b0;
      swap_found <= 1'b0;
      swap_hit   <= 1'b0;
    end else if (ctl.cmp) begin
      if (!ctl.self_agent && new_rd == cur_new) begin
        vertex_hit <= 1'b1;
      end
      // only the first agent whose old cell is our new cell counts
      if (!swap_found && old_rd == cur_new) begin
        swap_found <= 1'b1;
        swap_hit   <= !ctl.self_agent && new_rd == cur_old;
      end
    end
  end

  assign collide = vertex_hit | swap_hit;

endmodule
`default_nettype wire

// File: hdl/agent_collision_set_core.sv
// channel   dir   beat fields                                         handshake
// agents    in    new_row, new_col, old_row, old_col, last_agent      valid/ready
// result    out   collision_mask, agent_total, overflow               valid/ready
//
// loading takes agent beats as they are offered; a beat with last_agent set starts the check
// the check works through the n stored agents in turn: per agent one read of its own
// cells, then a sweep of both cell memories at one entry per cycle, then a drain
// the report then moves into the result register, and loading resumes
// a finished check waits for that register to free up; no agent beat is taken meanwhile
// synchronous reset clears the agent count, overflow flag, mask, result and sequencer;
// memory contents are not cleared, only entries written in the current set are read
`default_nettype none
module agent_collision_set_core import acs_pkg::*; #(
  parameter int MAX_AGENTS = MAX_AGENTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  acs_in_if.sink    agents,
  acs_out_if.source result
);

  localparam int AW     = $clog2(MAX_AGENTS);
  localparam int CW     = $clog2(MAX_AGENTS + 1);
  localparam int CELL_W = 2 * COORD_BITS;
  localparam int PAD_W  = COORD_MAX - FIELD_W;

  state_t state;
  state_t state_next;

  logic [CW-1:0]     count;      // agents stored in the current set
  logic              ovf;        // an agent was dropped in the current set
  logic [CW-1:0]     i;          // agent under test
  logic [CW-1:0]     k;          // next sweep entry to read
  logic              rd_valid;   // read data holds sweep entry rd_k
  logic [AW-1:0]     rd_k;
  logic [MASK_W-1:0] mask;

  // result register, parts the check from the receiver
  logic               res_valid;
  logic [MASK_W-1:0]  res_mask;
  logic [TOTAL_W-1:0] res_total;
  logic               res_ovf;

  logic              in_acc;
  logic              out_acc;
  logic              res_load;
  logic              store_ok;
  logic              issue;
  logic              finish;
  logic              collide;
  logic [AW-1:0]     raddr;
  cmp_ctl_t          ctl;

  logic [COORD_MAX-1:0] new_row_x;
  logic [COORD_MAX-1:0] new_col_x;
  logic [COORD_MAX-1:0] old_row_x;
  logic [COORD_MAX-1:0] old_col_x;
  logic [CELL_W-1:0]    new_wdata;
  logic [CELL_W-1:0]    old_wdata;
  logic [CELL_W-1:0]    new_rd;
  logic [CELL_W-1:0]    old_rd;
  logic [31:0]          i_x;
  logic [31:0]          count_x;

  assign in_acc   = agents.valid && agents.ready;
  assign out_acc  = result.valid && result.ready;
  assign res_load = (state == S_OUT) && (!res_valid || result.ready);
  assign store_ok = (count < CW'(MAX_AGENTS));
  assign issue    = (state == S_LATCH || state == S_SWEEP) && (k < count);
  assign finish   = (state == S_SWEEP) && (k == count) && !rd_valid;
  assign i_x      = 32'(i);
  assign count_x  = 32'(count);

  // a cell is {row, col}, each kept to its low COORD_BITS bits
  assign new_row_x = {{PAD_W{1'b0}}, agents.new_row};
  assign new_col_x = {{PAD_W{1'b0}}, agents.new_col};
  assign old_row_x = {{PAD_W{1'b0}}, agents.old_row};
  assign old_col_x = {{PAD_W{1'b0}}, agents.old_col};
  assign new_wdata = {new_row_x[COORD_BITS-1:0], new_col_x[COORD_BITS-1:0]};
  assign old_wdata = {old_row_x[COORD_BITS-1:0], old_col_x[COORD_BITS-1:0]};

  acs_ram #(.WIDTH(CELL_W), .DEPTH(MAX_AGENTS)) u_new_ram (
    .clk   (clk),
    .we    (in_acc && store_ok),
    .waddr (count[AW-1:0]),
    .wdata (new_wdata),
    .raddr (raddr),
    .rdata (new_rd)
  );

  acs_ram #(.WIDTH(CELL_W), .DEPTH(MAX_AGENTS)) u_old_ram (
    .clk   (clk),
    .we    (in_acc && store_ok),
    .waddr (count[AW-1:0]),
    .wdata (old_wdata),
    .raddr (raddr),
    .rdata (old_rd)
  );

  acs_cmp #(.CELL_W(CELL_W)) u_cmp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .new_rd  (new_rd),
    .old_rd  (old_rd),
    .collide (collide)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_acc && agents.last_agent) begin
          state_next = S_READ_I;
        end
      end
      S_READ_I: state_next = S_LATCH;
      S_LATCH:  state_next = S_SWEEP;
      S_SWEEP: begin
        if (finish) begin
          state_next = (i + CW'(1) == count) ? S_OUT : S_READ_I;
        end
      end
      S_OUT: begin
        if (res_load) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    agents.ready   = 1'b0;
    raddr          = k[AW-1:0];
    ctl.latch      = 1'b0;
    ctl.cmp        = 1'b0;
    ctl.self_agent = (rd_k == i[AW-1:0]);
    case (state)
      S_LOAD:   agents.ready = 1'b1;
      S_READ_I: raddr        = i[AW-1:0];
      S_LATCH:  ctl.latch    = 1'b1;
      S_SWEEP:  ctl.cmp      = rd_valid;
      default: begin
      end
    endcase
  end

  assign result.valid          = res_valid;
  assign result.collision_mask = res_mask;
  assign result.agent_total    = res_total;
  assign result.overflow       = res_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      i         <= '0;
      k         <= '0;
      rd_valid  <= 1'b0;
      rd_k      <= '0;
      mask      <= '0;
      res_valid <= 1'b0;
      res_mask  <= '0;
      res_total <= '0;
      res_ovf   <= 1'b0;
    end else begin
      state <= state_next;

      // store the agent, or note the drop when full
      if (in_acc) begin
        if (store_ok) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
        i <= '0;
      end

      if (state == S_READ_I) begin
        k <= '0;
      end

      // sweep issue: one entry of both memories per cycle
      if (state == S_LATCH || state == S_SWEEP) begin
        if (issue) begin
          k        <= k + CW'(1);
          rd_valid <= 1'b1;
          rd_k     <= k[AW-1:0];
        end else begin
          rd_valid <= 1'b0;
        end
      end

      // agents numbered 16 and above have no mask bit
      if (finish) begin
        if (collide && i_x < 32'(MASK_W)) begin
          mask[i_x[3:0]] <= 1'b1;
        end
        i <= i + CW'(1);
      end

      // hand the report over and open the next set
      if (res_load) begin
        res_valid <= 1'b1;
        res_mask  <= mask;
        res_total <= count_x[TOTAL_W-1:0];
        res_ovf   <= ovf;
        count     <= '0;
        ovf       <= 1'b0;
        mask      <= '0;
      end else if (out_acc) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
// agent collision set: block-level check
// agent beats are queued up front, driven on the falling edge and taken at the rising edge
// every accepted beat is loaded into a local copy of the agent store; a beat with
// last_agent set closes the set and yields one expected report (mask, total, overflow)
// result beats are popped in order and compared field by field
module testbench;
  import acs_pkg::*;

  localparam int AGENTS       = MAX_AGENTS_DEF;
  localparam int CBITS        = COORD_BITS_DEF;
  localparam int BEAT_TARGET  = 1200;
  localparam int HOLD_CYCLES  = 600;   // long receiver hold, well past one full check
  localparam int HOLD_SPACING = 90;    // results between long holds
  localparam int DRAIN_CYCLES = 400;   // longer than the worst check
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [FIELD_W-1:0] new_row;
    logic [FIELD_W-1:0] new_col;
    logic [FIELD_W-1:0] old_row;
    logic [FIELD_W-1:0] old_col;
    logic               last;
    logic               hold;    // sender waits for all reports before offering this beat
  } agent_beat_t;

  typedef struct {
    logic [MASK_W-1:0]  mask;
    logic [TOTAL_W-1:0] total;
    logic               ovf;
  } collision_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  acs_in_if  agents_bus ();
  acs_out_if result_bus ();

  agent_collision_set_core #(
    .MAX_AGENTS (AGENTS),
    .COORD_BITS (CBITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .agents (agents_bus),
    .result (result_bus)
  );

  always #5 clk = ~clk;

  // pending stimulus and outstanding reports
  agent_beat_t       agents_to_send[$];
  collision_report_t reports_due[$];

  // local copy of the agent store, cells packed as {row, col}
  int unsigned new_cells [AGENTS];
  int unsigned old_cells [AGENTS];
  int          stored  = 0;
  logic        dropped = 1'b0;

  // bookkeeping
  int queued_beats    = 0;
  int items_sent      = 0;
  int beats_in        = 0;
  int results_seen    = 0;
  int sets_checked    = 0;
  int sets_overflowed = 0;
  int sets_colliding  = 0;
  int mismatches      = 0;

  // handshake flags passed from the rising-edge samplers to the falling-edge drivers
  logic offer_taken  = 1'b0;
  logic result_taken = 1'b0;
  logic offering     = 1'b0;
  int   gap_left     = 0;
  int   rx_wait      = 0;
  int   hold_left    = 0;
  int   next_hold_at = 6;

  agent_beat_t       taken_beat;
  agent_beat_t       next_beat;
  collision_report_t want_rep;

  // a cell keeps only the low CBITS of each coordinate
  function automatic int unsigned cell_of(logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col);
    int unsigned m;
    m = (1 << CBITS) - 1;
    return ((int'(row) & m) << CBITS) | (int'(col) & m);
  endfunction

  // vertex: shared new cell; swap: lowest agent whose old cell is my new cell
  // must have moved into my old cell, and must not be me
  function automatic logic [MASK_W-1:0] collision_mask_of(int n);
    logic [MASK_W-1:0] m;
    logic              hit;
    int                j;
    m = '0;
    for (int i = 0; i < n && i < MASK_W; i++) begin
      hit = 1'b0;
      for (int k = 0; k < n; k++)
        if (k != i && new_cells[k] == new_cells[i]) hit = 1'b1;
      j = -1;
      for (int k = n - 1; k >= 0; k--)
        if (old_cells[k] == new_cells[i]) j = k;
      if (j >= 0 && j != i && new_cells[j] == old_cells[i]) hit = 1'b1;
      m[i] = hit;
    end
    return m;
  endfunction

  // store one agent; a last beat closes the set and queues its report
  task automatic load_agent(agent_beat_t b);
    collision_report_t rep;
    if (stored < AGENTS) begin
      new_cells[stored] = cell_of(b.new_row, b.new_col);
      old_cells[stored] = cell_of(b.old_row, b.old_col);
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (b.last) begin
      rep.mask  = collision_mask_of(stored);
      rep.total = TOTAL_W'(stored);
      rep.ovf   = dropped;
      reports_due.push_back(rep);
      sets_checked++;
      if (dropped) sets_overflowed++;
      if (rep.mask != '0) sets_colliding++;
      stored  = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s differs: expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic push_agent(logic [FIELD_W-1:0] nr, logic [FIELD_W-1:0] nc,
                            logic [FIELD_W-1:0] pr, logic [FIELD_W-1:0] pc,
                            logic last, logic hold);
    agent_beat_t b;
    b.new_row = nr;
    b.new_col = nc;
    b.old_row = pr;
    b.old_col = pc;
    b.last    = last;
    b.hold    = hold;
    agents_to_send.push_back(b);
    queued_beats++;
  endtask

  // one set of n agents; most sets crowd a few cells so collisions are common,
  // some copy an earlier agent's move backwards to build swaps, a few are fully random
  task automatic queue_random_set(int n, logic hold);
    logic [FIELD_W-1:0] cur_r [20];
    logic [FIELD_W-1:0] cur_c [20];
    logic [FIELD_W-1:0] prv_r [20];
    logic [FIELD_W-1:0] prv_c [20];
    logic [FIELD_W-1:0] base_r;
    logic [FIELD_W-1:0] base_c;
    int                 style;
    int                 p;
    base_r = FIELD_W'($urandom);
    base_c = FIELD_W'($urandom);
    style  = $urandom_range(0, 9);
    for (int k = 0; k < n; k++) begin
      if (style < 2) begin
        cur_r[k] = FIELD_W'($urandom);
        cur_c[k] = FIELD_W'($urandom);
        prv_r[k] = FIELD_W'($urandom);
        prv_c[k] = FIELD_W'($urandom);
      end else begin
        cur_r[k] = base_r + FIELD_W'($urandom_range(0, 3));
        cur_c[k] = base_c + FIELD_W'($urandom_range(0, 3));
        prv_r[k] = base_r + FIELD_W'($urandom_range(0, 3));
        prv_c[k] = base_c + FIELD_W'($urandom_range(0, 3));
        if (style >= 6 && k > 0 && $urandom_range(0, 1) == 1) begin
          p = $urandom_range(0, k - 1);
          cur_r[k] = prv_r[p];
          cur_c[k] = prv_c[p];
          prv_r[k] = cur_r[p];
          prv_c[k] = cur_c[p];
        end
      end
      push_agent(cur_r[k], cur_c[k], prv_r[k], prv_c[k], k == n - 1, hold && k == 0);
    end
  endtask

  // sender idles for a random gap after each beat, with a stretch of back-to-back beats every 100
  function automatic int draw_gap();
    return (items_sent % 100 < 25) ? 0 : $urandom_range(0, 4);
  endfunction

  // ---------------------------------------------------------------------------
  // agent driver: falling edge, one valid assignment per step
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      offering = 1'b0;
      gap_left = 0;
      agents_bus.valid <= 1'b0;
    end else begin
      if (offer_taken) begin
        offer_taken = 1'b0;
        offering    = 1'b0;
        gap_left    = draw_gap();
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (agents_to_send.size() > 0 &&
                     !(agents_to_send[0].hold && reports_due.size() > 0)) begin
          next_beat = agents_to_send.pop_front();
          agents_bus.new_row    <= next_beat.new_row;
          agents_bus.new_col    <= next_beat.new_col;
          agents_bus.old_row    <= next_beat.old_row;
          agents_bus.old_col    <= next_beat.old_col;
          agents_bus.last_agent <= next_beat.last;
          offering = 1'b1;
          items_sent++;
        end
      end
      agents_bus.valid <= offering;
    end
  end

  // accepted agent beats feed the local store
  always @(posedge clk) begin
    if (!rst && agents_bus.valid && agents_bus.ready) begin
      taken_beat.new_row = agents_bus.new_row;
      taken_beat.new_col = agents_bus.new_col;
      taken_beat.old_row = agents_bus.old_row;
      taken_beat.old_col = agents_bus.old_col;
      taken_beat.last    = agents_bus.last_agent;
      taken_beat.hold    = 1'b0;
      load_agent(taken_beat);
      offer_taken = 1'b1;
      beats_in++;
    end
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // long receiver hold, counted on its own so the block fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (results_seen >= next_hold_at) begin
      hold_left    = HOLD_CYCLES;
      next_hold_at = results_seen + HOLD_SPACING;
    end
  end

  // receiver idles for a random gap after each result beat, none in the first 16 of every 64
  always @(negedge clk) begin
    if (rst) begin
      rx_wait = 0;
      result_bus.ready <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        rx_wait      = (results_seen % 64 < 16) ? 0 : $urandom_range(0, 4);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      result_bus.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // compare each result beat against the oldest open report
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      result_taken = 1'b1;
      results_seen <= results_seen + 1;
      if (reports_due.size() == 0) begin
        flag_mismatch("unexpected result beat, mask", 0, result_bus.collision_mask);
      end else begin
        want_rep = reports_due.pop_front();
        if (result_bus.collision_mask !== want_rep.mask)
          flag_mismatch("collision_mask", want_rep.mask, result_bus.collision_mask);
        if (result_bus.agent_total !== want_rep.total)
          flag_mismatch("agent_total", want_rep.total, result_bus.agent_total);
        if (result_bus.overflow !== want_rep.ovf)
          flag_mismatch("overflow", want_rep.ovf, result_bus.overflow);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int set_idx;
    int n;
    int pick;

    // lone agent at the origin: nothing to collide with
    push_agent(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    // two agents landing on the same cell
    push_agent(8'd5, 8'd5, 8'd1, 8'd1, 1'b0, 1'b0);
    push_agent(8'd5, 8'd5, 8'd9, 8'd9, 1'b1, 1'b0);
    // two agents trading places
    push_agent(8'd2, 8'd2, 8'd1, 8'd1, 1'b0, 1'b0);
    push_agent(8'd1, 8'd1, 8'd2, 8'd2, 1'b1, 1'b0);
    // swap partner hidden behind a lower agent with the same old cell:
    // only the third agent is marked
    push_agent(8'd3, 8'd3, 8'd4, 8'd4, 1'b0, 1'b0);
    push_agent(8'd7, 8'd7, 8'd3, 8'd3, 1'b0, 1'b0);
    push_agent(8'd4, 8'd4, 8'd3, 8'd3, 1'b1, 1'b0);
    // full store plus one dropped agent carrying the last flag; coordinate extremes,
    // agents standing still, and a quiet pipe before the set starts
    for (int k = 0; k <= AGENTS; k++) begin
      if (k == 0)
        push_agent(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
      else if (k == 1)
        push_agent(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
      else
        push_agent(FIELD_W'(k), FIELD_W'(k * 16), FIELD_W'(255 - k), FIELD_W'(k),
                   k == AGENTS, 1'b0);
    end

    // random sets: mostly short, some up to a full store, a few overflowing
    set_idx = 0;
    while (queued_beats < BEAT_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      n = $urandom_range(1, 5);
      else if (pick < 90) n = $urandom_range(6, AGENTS);
      else                n = $urandom_range(AGENTS + 1, AGENTS + 4);
      queue_random_set(n, set_idx == 3 || set_idx % 40 == 39);
      set_idx++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (agents_to_send.size() > 0 || offering || reports_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d agent beats in %0d sets: %0d with collisions, %0d overflowing",
             beats_in, sets_checked, sets_colliding, sets_overflowed);
    $display("%0d result beats compared, %0d field differences", results_seen, mismatches);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #20_000_000;
    $display("timeout: %0d reports still open", reports_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hdl/acs_pkg.sv
hdl/acs_in_if.sv
hdl/acs_out_if.sv
hdl/acs_ram.sv
hdl/acs_cmp.sv
hdl/agent_collision_set_core.sv
sim/testbench.sv
